/* rtl/core/assert_macros.svh */
// assertion helpers shared by the core rtl
// both sample on the rising edge of clk and are off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DCS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/dcs_pkg.sv */
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared types and constants of the demand current settler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcs_pkg;

  localparam int PLUG_NUM_W = 4;
  localparam int CURRENT_W  = 16;
  localparam int FLUCT_W    = 16;
  localparam int LIMIT_W    = 5;
  localparam int DEC_W      = 6;
  localparam int GATE_W     = 16;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // holds the ring sum of up to 63 samples
  localparam int ALU_W = CURRENT_W + 6;

  // register indexes, byte address is 4x index
  localparam logic [2:0] REG_FLUCT_LIMIT = 3'd0;
  localparam logic [2:0] REG_FALL_LIMIT  = 3'd1;
  localparam logic [2:0] REG_RISE_LIMIT  = 3'd2;
  localparam logic [2:0] REG_FALL_PEN    = 3'd3;
  localparam logic [2:0] REG_RISE_PEN    = 3'd4;
  localparam logic [2:0] REG_DECIMATION  = 3'd5;
  localparam logic [2:0] REG_ACT_GATE    = 3'd6;

  localparam logic [FLUCT_W-1:0] RST_FLUCT_LIMIT = 16'd500;
  localparam logic [LIMIT_W-1:0] RST_FALL_LIMIT  = 5'd18;
  localparam logic [LIMIT_W-1:0] RST_RISE_LIMIT  = 5'd3;
  localparam logic [LIMIT_W-1:0] RST_FALL_PEN    = 5'd6;
  localparam logic [LIMIT_W-1:0] RST_RISE_PEN    = 5'd1;
  localparam logic [DEC_W-1:0]   RST_DECIMATION  = 6'd30;
  localparam logic [GATE_W-1:0]  RST_ACT_GATE    = 16'd3600;

  typedef struct packed {
    logic [FLUCT_W-1:0] fluct_limit;
    logic [LIMIT_W-1:0] fall_limit;
    logic [LIMIT_W-1:0] rise_limit;
    logic [LIMIT_W-1:0] fall_penalty;
    logic [LIMIT_W-1:0] rise_penalty;
    logic [DEC_W-1:0]   decimation;
    logic [GATE_W-1:0]  act_gate;
  } cfg_t;

  typedef enum logic [0:0] {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             borrow;
  } alu_rsp_t;

endpackage

/* rtl/core/dcs_ifs.sv */
// ----------------------------------------------------------------------------
// dcs_ifs
// Request and result channels, valid/ready with payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dcs_in_if;
  logic                           valid;
  logic                           ready;
  logic [dcs_pkg::PLUG_NUM_W-1:0] plug_number;
  logic [dcs_pkg::CURRENT_W-1:0]  demand_current;

  modport source (output valid, output plug_number, output demand_current, input ready);
  modport sink   (input valid, input plug_number, input demand_current, output ready);
endinterface

interface dcs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          settled;
  logic [dcs_pkg::CURRENT_W-1:0] stable_current;

  modport source (output valid, output settled, output stable_current, input ready);
  modport sink   (input valid, input settled, input stable_current, output ready);
endinterface

/* rtl/core/demand_current_settler_core.sv */
// ----------------------------------------------------------------------------
// demand_current_settler_core
// Per-plug settle tracking of demand current samples, sequenced over one
// shared add/subtract unit.
//
//   channel   dir  handshake            payload
//   in_ch     in   valid/ready          plug_number, demand_current
//   out_ch    out  valid/ready          settled, stable_current
//   cfg_*     in   psel/penable/pready  paddr, pwdata, prdata
//
// An ignored plug or a gated call skips to S_OUT and frees the input on its load.
// A processed call does one ring read per cycle for the three trend slots and
// the SAMPLE_DEPTH-1 sum slots, one reciprocal multiply for the mean, then
// the unit steps DEV1, DEV2, CMP, CNT and CLAMP before writeback.
// The output register holds a result while out_ch stalls; the next request
// is taken meanwhile and waits only at its own result load.
// Reset is synchronous and needs no clearing pass: ring entries beyond a
// plug's write pointer read as zero until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module demand_current_settler_core #(
  parameter int NUM_PLUGS    = 8,
  parameter int SAMPLE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  dcs_in_if.sink                         in_ch,
  dcs_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [dcs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [dcs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [dcs_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int PLUG_W = (NUM_PLUGS > 1) ? $clog2(NUM_PLUGS) : 1;
  localparam int SLOT_W = $clog2(SAMPLE_DEPTH);
  localparam int WP_W   = $clog2(SAMPLE_DEPTH + 1);
  localparam int STEP_W = $clog2(SAMPLE_DEPTH + 3);
  localparam int ADDR_W = PLUG_W + SLOT_W;
  localparam int CUR_W  = dcs_pkg::CURRENT_W;
  localparam int ALU_W  = dcs_pkg::ALU_W;
  localparam int LIM_W  = dcs_pkg::LIMIT_W;

  // floor(sum / (depth-1)) as (sum * RECIP) >> DIV_SH, exact below 2**ALU_W
  localparam int     DIV_SH  = ALU_W + $clog2(SAMPLE_DEPTH - 1);
  localparam int     RECIP_W = ALU_W + 1;
  localparam int     PROD_W  = ALU_W + RECIP_W;
  localparam longint DIV_D   = longint'(SAMPLE_DEPTH - 1);
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((longint'(1) << DIV_SH) + DIV_D - longint'(1)) / DIV_D);

  localparam logic [dcs_pkg::PLUG_NUM_W-1:0] LAST_PLUG = dcs_pkg::PLUG_NUM_W'(NUM_PLUGS);
  localparam logic [STEP_W-1:0] TREND_N   = STEP_W'(3);
  localparam logic [STEP_W-1:0] LAST_RD   = STEP_W'(SAMPLE_DEPTH + 1);
  localparam logic [WP_W-1:0]   WP_DEPTH  = WP_W'(SAMPLE_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SAMPLE_DEPTH - 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_READ  = 10'b0000000010,
    S_DIV   = 10'b0000000100,
    S_DEV1  = 10'b0000001000,
    S_DEV2  = 10'b0000010000,
    S_CMP   = 10'b0000100000,
    S_CNT   = 10'b0001000000,
    S_CLAMP = 10'b0010000000,
    S_WB    = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  dcs_pkg::cfg_t     cfg;
  dcs_pkg::alu_req_t alu_req;
  dcs_pkg::alu_rsp_t alu_rsp;

  // per-plug state
  logic [dcs_pkg::GATE_W-1:0] call_r   [NUM_PLUGS];
  logic [dcs_pkg::DEC_W-1:0]  phase_r  [NUM_PLUGS];
  logic [WP_W-1:0]            wp_r     [NUM_PLUGS];
  logic                       ovf_r    [NUM_PLUGS];
  logic [LIM_W-1:0]           settle_r [NUM_PLUGS];

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [PLUG_W-1:0]  k_r, k_nxt;
  logic [CUR_W-1:0]   cur_r, cur_nxt;
  logic [ALU_W-1:0]   acc_r, acc_nxt;
  logic [CUR_W-1:0]   a_r, a_nxt;
  logic [CUR_W-1:0]   b_r, b_nxt;
  logic [2:0]         lt_r, lt_nxt;
  logic               neg_r, neg_nxt;
  logic [CUR_W-1:0]   dev_r, dev_nxt;
  logic               unstable_r, unstable_nxt;
  logic [LIM_W:0]     cnt_r, cnt_nxt;
  logic               rd_vld_r;
  logic [STEP_W-1:0]  rd_tag_r;
  logic               rd_ok_r;
  logic               res_settled_r, res_settled_nxt;
  logic [CUR_W-1:0]   res_current_r, res_current_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic               out_settled_r, out_settled_nxt;
  logic [CUR_W-1:0]   out_current_r, out_current_nxt;

  // accept-cycle per-plug update
  logic                       in_fire;
  logic                       plug_ok;
  logic [PLUG_W-1:0]          k_in;
  logic                       cnt_we;
  logic [dcs_pkg::GATE_W-1:0] call_nxt;
  logic [dcs_pkg::DEC_W-1:0]  phase_nxt;
  logic [dcs_pkg::DEC_W:0]    phase_inc;
  logic [dcs_pkg::DEC_W-1:0]  dec_eff;

  // writeback of the active plug
  logic               wb_we;
  logic [WP_W-1:0]    wp_nxt;
  logic               ovf_nxt;
  logic [LIM_W-1:0]   settle_nxt;
  logic [SLOT_W-1:0]  wr_slot;

  // ring read issue
  logic               rd_issue;
  logic [SLOT_W-1:0]  rd_slot;
  logic               rd_ok;
  logic [2:0]         rd_back;
  logic [CUR_W-1:0]   ring_rdata;
  logic [CUR_W-1:0]   rd_data;

  logic [WP_W-1:0]    wp_cur;
  logic               ovf_cur;
  logic [CUR_W-1:0]   mean;
  logic               falling;
  logic [LIM_W-1:0]   limit;
  logic [LIM_W-1:0]   penalty;
  logic [PROD_W-1:0]  prod;
  logic [CUR_W-1:0]   quot;
  logic               out_free;
  logic               settled_now;

  function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] p,
                                                  input logic [2:0] back);
    logic [SLOT_W:0] t;
    t = {1'b0, p} + (SLOT_W+1)'(SAMPLE_DEPTH) - (SLOT_W+1)'(back);
    if (t >= (SLOT_W+1)'(SAMPLE_DEPTH)) begin
      t = t - (SLOT_W+1)'(SAMPLE_DEPTH);
    end
    return t[SLOT_W-1:0];
  endfunction

  dcs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  dcs_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  dcs_ring #(
    .ADDR_W (ADDR_W)
  ) u_ring (
    .clk   (clk),
    .we    (wb_we),
    .waddr ({k_r, wr_slot}),
    .wdata (cur_r),
    .re    (rd_issue),
    .raddr ({k_r, rd_slot}),
    .rdata (ring_rdata)
  );

  assign in_ch.ready           = (state_r == S_IDLE);
  assign in_fire               = in_ch.valid && in_ch.ready;
  assign out_ch.valid          = out_vld_r;
  assign out_ch.settled        = out_settled_r;
  assign out_ch.stable_current = out_current_r;
  assign out_free              = !out_vld_r || out_ch.ready;

  assign plug_ok = (in_ch.plug_number != '0) && (in_ch.plug_number <= LAST_PLUG);
  assign k_in    = PLUG_W'(in_ch.plug_number - dcs_pkg::PLUG_NUM_W'(1));
  assign dec_eff = (cfg.decimation == '0) ? dcs_pkg::DEC_W'(1) : cfg.decimation;

  assign wp_cur   = wp_r[k_r];
  assign ovf_cur  = ovf_r[k_r];
  assign mean     = acc_r[CUR_W-1:0];
  assign falling  = ovf_cur && (&lt_r);
  assign limit    = falling ? cfg.fall_limit : cfg.rise_limit;
  assign penalty  = falling ? cfg.fall_penalty : cfg.rise_penalty;
  assign rd_data  = rd_ok_r ? ring_rdata : '0;
  assign prod     = PROD_W'(acc_r) * PROD_W'(RECIP);
  assign quot     = prod[DIV_SH +: CUR_W];
  assign settled_now = (cnt_r == {1'b0, limit});

  // read issue: three trend slots, then ring slots 0..depth-2
  always_comb begin
    rd_issue = (state_r == S_READ) && (step_r <= LAST_RD);
    rd_back  = 3'(({1'b0, step_r[1:0]} + 3'd1) << 1);
    if (step_r < TREND_N) begin
      rd_slot = slot_back(wp_cur[SLOT_W-1:0], rd_back);
      rd_ok   = ovf_cur;
    end else begin
      rd_slot = SLOT_W'(step_r - TREND_N);
      rd_ok   = ovf_cur || (WP_W'(rd_slot) < wp_cur);
    end
  end

  // slot written and pointer update of the active plug
  always_comb begin
    if (ovf_cur) begin
      wr_slot = wp_cur[SLOT_W-1:0];
      wp_nxt  = (wp_cur[SLOT_W-1:0] == SLOT_LAST) ? '0 : wp_cur + WP_W'(1);
      ovf_nxt = 1'b1;
    end else if (wp_cur == WP_DEPTH) begin
      wr_slot = '0;
      wp_nxt  = WP_W'(1);
      ovf_nxt = 1'b1;
    end else begin
      wr_slot = wp_cur[SLOT_W-1:0];
      wp_nxt  = wp_cur + WP_W'(1);
      ovf_nxt = 1'b0;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    k_nxt           = k_r;
    cur_nxt         = cur_r;
    acc_nxt         = acc_r;
    a_nxt           = a_r;
    b_nxt           = b_r;
    lt_nxt          = lt_r;
    neg_nxt         = neg_r;
    dev_nxt         = dev_r;
    unstable_nxt    = unstable_r;
    cnt_nxt         = cnt_r;
    res_settled_nxt = res_settled_r;
    res_current_nxt = res_current_r;
    out_vld_nxt     = out_vld_r && !out_ch.ready;
    out_settled_nxt = out_settled_r;
    out_current_nxt = out_current_r;
    alu_req.op      = dcs_pkg::ALU_ADD;
    alu_req.a       = '0;
    alu_req.b       = '0;
    cnt_we          = 1'b0;
    call_nxt        = '0;
    phase_nxt       = '0;
    phase_inc       = '0;
    wb_we           = 1'b0;
    settle_nxt      = cnt_r[LIM_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          k_nxt           = k_in;
          cur_nxt         = in_ch.demand_current;
          acc_nxt         = '0;
          step_nxt        = '0;
          res_settled_nxt = 1'b0;
          res_current_nxt = '0;
          state_nxt       = S_OUT;
          if (plug_ok) begin
            cnt_we    = 1'b1;
            call_nxt  = (call_r[k_in] < cfg.act_gate) ?
                        call_r[k_in] + dcs_pkg::GATE_W'(1) : call_r[k_in];
            phase_inc = {1'b0, phase_r[k_in]} + (dcs_pkg::DEC_W+1)'(1);
            phase_nxt = (phase_inc >= {1'b0, dec_eff}) ?
                        '0 : phase_inc[dcs_pkg::DEC_W-1:0];
            if ((call_nxt >= cfg.act_gate) && (phase_nxt == '0)) begin
              state_nxt = S_READ;
            end
          end
        end
      end

      S_READ: begin
        if (rd_issue) begin
          step_nxt = step_r + STEP_W'(1);
        end
        if (rd_vld_r) begin
          alu_req.op = dcs_pkg::ALU_SUB;
          alu_req.b  = ALU_W'(rd_data);
          if (rd_tag_r == STEP_W'(0)) begin
            alu_req.a = ALU_W'(cur_r);
            a_nxt     = rd_data;
            lt_nxt[0] = alu_rsp.borrow;
          end else if (rd_tag_r == STEP_W'(1)) begin
            alu_req.a = ALU_W'(a_r);
            b_nxt     = rd_data;
            lt_nxt[1] = alu_rsp.borrow;
          end else if (rd_tag_r == STEP_W'(2)) begin
            alu_req.a = ALU_W'(b_r);
            lt_nxt[2] = alu_rsp.borrow;
          end else begin
            alu_req.op = dcs_pkg::ALU_ADD;
            alu_req.a  = acc_r;
            acc_nxt    = alu_rsp.res;
            if (rd_tag_r == LAST_RD) begin
              // sum complete, the mean follows
              step_nxt  = '0;
              state_nxt = S_DIV;
            end
          end
        end
      end

      // mean by reciprocal multiply of the ring sum
      S_DIV: begin
        acc_nxt   = ALU_W'(quot);
        state_nxt = S_DEV1;
      end

      S_DEV1: begin
        alu_req.op = dcs_pkg::ALU_SUB;
        alu_req.a  = ALU_W'(cur_r);
        alu_req.b  = ALU_W'(mean);
        neg_nxt    = alu_rsp.borrow;
        state_nxt  = S_DEV2;
      end

      S_DEV2: begin
        alu_req.op = dcs_pkg::ALU_SUB;
        alu_req.a  = neg_r ? ALU_W'(mean) : ALU_W'(cur_r);
        alu_req.b  = neg_r ? ALU_W'(cur_r) : ALU_W'(mean);
        dev_nxt    = alu_rsp.res[CUR_W-1:0];
        state_nxt  = S_CMP;
      end

      S_CMP: begin
        alu_req.op   = dcs_pkg::ALU_SUB;
        alu_req.a    = ALU_W'(cfg.fluct_limit);
        alu_req.b    = ALU_W'(dev_r);
        unstable_nxt = alu_rsp.borrow;
        state_nxt    = S_CNT;
      end

      S_CNT: begin
        alu_req.a = ALU_W'(settle_r[k_r]);
        if (unstable_r) begin
          alu_req.op = dcs_pkg::ALU_SUB;
          alu_req.b  = ALU_W'(penalty);
          cnt_nxt    = alu_rsp.borrow ? '0 : alu_rsp.res[LIM_W:0];
        end else begin
          alu_req.op = dcs_pkg::ALU_ADD;
          alu_req.b  = ALU_W'(1);
          cnt_nxt    = alu_rsp.res[LIM_W:0];
        end
        state_nxt = S_CLAMP;
      end

      // stable step saturates at the active limit
      S_CLAMP: begin
        alu_req.op = dcs_pkg::ALU_SUB;
        alu_req.a  = ALU_W'(cnt_r);
        alu_req.b  = ALU_W'(limit);
        if (!unstable_r && !alu_rsp.borrow) begin
          cnt_nxt = {1'b0, limit};
        end
        state_nxt = S_WB;
      end

      S_WB: begin
        wb_we           = 1'b1;
        res_settled_nxt = settled_now;
        res_current_nxt = settled_now ? mean : '0;
        state_nxt       = S_OUT;
      end

      S_OUT: begin
        if (out_free) begin
          out_vld_nxt     = 1'b1;
          out_settled_nxt = res_settled_r;
          out_current_nxt = res_current_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_vld_r  <= rd_issue;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r        <= step_nxt;
    k_r           <= k_nxt;
    cur_r         <= cur_nxt;
    acc_r         <= acc_nxt;
    a_r           <= a_nxt;
    b_r           <= b_nxt;
    lt_r          <= lt_nxt;
    neg_r         <= neg_nxt;
    dev_r         <= dev_nxt;
    unstable_r    <= unstable_nxt;
    cnt_r         <= cnt_nxt;
    rd_tag_r      <= step_r;
    rd_ok_r       <= rd_ok;
    res_settled_r <= res_settled_nxt;
    res_current_r <= res_current_nxt;
    out_settled_r <= out_settled_nxt;
    out_current_r <= out_current_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PLUGS; i++) begin
        call_r[i]   <= '0;
        phase_r[i]  <= '0;
        wp_r[i]     <= '0;
        ovf_r[i]    <= 1'b0;
        settle_r[i] <= '0;
      end
    end else begin
      if (cnt_we) begin
        call_r[k_in]  <= call_nxt;
        phase_r[k_in] <= phase_nxt;
      end
      if (wb_we) begin
        wp_r[k_r]     <= wp_nxt;
        ovf_r[k_r]    <= ovf_nxt;
        settle_r[k_r] <= settle_nxt;
      end
    end
  end

  `DCS_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_r != S_IDLE, "request accepted but sequencer stayed idle")
  `DCS_ASSERT_NEXT(a_out_hold, out_vld_r && !out_ch.ready, out_vld_r && $stable(out_current_r) && $stable(out_settled_r), "result changed while stalled")
  `DCS_ASSERT_SAME(a_unsettled_zero, out_vld_r && !out_settled_r, out_current_r == '0, "unsettled result carries a current")
  `DCS_ASSERT_SAME(a_wp_range, state_r == S_WB, (wp_cur <= WP_DEPTH) && (!ovf_cur || (wp_cur < WP_DEPTH)), "write pointer out of range")

endmodule

/* rtl/core/dcs_alu.sv */
// ----------------------------------------------------------------------------
// dcs_alu
// Shared add/subtract unit; subtract also reports a borrow (a < b).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcs_alu (
  input  dcs_pkg::alu_req_t req,
  output dcs_pkg::alu_rsp_t rsp
);

  logic [dcs_pkg::ALU_W:0] wide;

  always_comb begin
    case (req.op)
      dcs_pkg::ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
      dcs_pkg::ALU_SUB: wide = {1'b0, req.a} - {1'b0, req.b};
      default:          wide = '0;
    endcase
    rsp.res    = wide[dcs_pkg::ALU_W-1:0];
    rsp.borrow = (req.op == dcs_pkg::ALU_SUB) ? wide[dcs_pkg::ALU_W] : 1'b0;
  end

endmodule

/* rtl/core/dcs_ring.sv */
// ----------------------------------------------------------------------------
// dcs_ring
// Sample ring store for all plugs, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcs_ring #(
  parameter int ADDR_W = 7
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ADDR_W-1:0]             waddr,
  input  logic [dcs_pkg::CURRENT_W-1:0] wdata,
  input  logic                          re,
  input  logic [ADDR_W-1:0]             raddr,
  output logic [dcs_pkg::CURRENT_W-1:0] rdata
);

  logic [dcs_pkg::CURRENT_W-1:0] mem [2**ADDR_W];
  logic [dcs_pkg::CURRENT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/dcs_cfg.sv */
// ----------------------------------------------------------------------------
// dcs_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcs_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dcs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [dcs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [dcs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output dcs_pkg::cfg_t                  cfg
);

  dcs_pkg::cfg_t cfg_r;
  dcs_pkg::cfg_t cfg_nxt;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        dcs_pkg::REG_FLUCT_LIMIT: cfg_nxt.fluct_limit  = pwdata[dcs_pkg::FLUCT_W-1:0];
        dcs_pkg::REG_FALL_LIMIT:  cfg_nxt.fall_limit   = pwdata[dcs_pkg::LIMIT_W-1:0];
        dcs_pkg::REG_RISE_LIMIT:  cfg_nxt.rise_limit   = pwdata[dcs_pkg::LIMIT_W-1:0];
        dcs_pkg::REG_FALL_PEN:    cfg_nxt.fall_penalty = pwdata[dcs_pkg::LIMIT_W-1:0];
        dcs_pkg::REG_RISE_PEN:    cfg_nxt.rise_penalty = pwdata[dcs_pkg::LIMIT_W-1:0];
        dcs_pkg::REG_DECIMATION:  cfg_nxt.decimation   = pwdata[dcs_pkg::DEC_W-1:0];
        dcs_pkg::REG_ACT_GATE:    cfg_nxt.act_gate     = pwdata[dcs_pkg::GATE_W-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dcs_pkg::REG_FLUCT_LIMIT: prdata = dcs_pkg::CFG_DATA_W'(cfg_r.fluct_limit);
      dcs_pkg::REG_FALL_LIMIT:  prdata = dcs_pkg::CFG_DATA_W'(cfg_r.fall_limit);
      dcs_pkg::REG_RISE_LIMIT:  prdata = dcs_pkg::CFG_DATA_W'(cfg_r.rise_limit);
      dcs_pkg::REG_FALL_PEN:    prdata = dcs_pkg::CFG_DATA_W'(cfg_r.fall_penalty);
      dcs_pkg::REG_RISE_PEN:    prdata = dcs_pkg::CFG_DATA_W'(cfg_r.rise_penalty);
      dcs_pkg::REG_DECIMATION:  prdata = dcs_pkg::CFG_DATA_W'(cfg_r.decimation);
      dcs_pkg::REG_ACT_GATE:    prdata = dcs_pkg::CFG_DATA_W'(cfg_r.act_gate);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fluct_limit  <= dcs_pkg::RST_FLUCT_LIMIT;
      cfg_r.fall_limit   <= dcs_pkg::RST_FALL_LIMIT;
      cfg_r.rise_limit   <= dcs_pkg::RST_RISE_LIMIT;
      cfg_r.fall_penalty <= dcs_pkg::RST_FALL_PEN;
      cfg_r.rise_penalty <= dcs_pkg::RST_RISE_PEN;
      cfg_r.decimation   <= dcs_pkg::RST_DECIMATION;
      cfg_r.act_gate     <= dcs_pkg::RST_ACT_GATE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* tb/sv/demand_current_settler_checker.sv */
// ----------------------------------------------------------------------------
// demand_current_settler_checker
// Follows the register port, predicts the settle result of every request
// and compares each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module demand_current_settler_checker #(
  parameter int NUM_PLUGS    = 8,
  parameter int SAMPLE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  dcs_in_if                              in_ch,
  dcs_out_if                             out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic                           cfg_pready,
  input  logic [dcs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [dcs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output int                             errors,
  output int                             pending,
  output int                             settled_hits,
  output int                             falling_hits
);
  import dcs_pkg::*;

  typedef struct packed {
    logic                 settled;
    logic [CURRENT_W-1:0] stable_current;
  } settle_result_t;

  cfg_t                 regs;
  logic [GATE_W-1:0]    call_cnt   [NUM_PLUGS];
  logic [DEC_W-1:0]     phase_cnt  [NUM_PLUGS];
  int                   wr_ptr     [NUM_PLUGS];
  logic                 overfilled [NUM_PLUGS];
  logic [LIMIT_W-1:0]   settle_cnt [NUM_PLUGS];
  logic [CURRENT_W-1:0] ring       [NUM_PLUGS][SAMPLE_DEPTH];
  settle_result_t       settle_results_due [$];

  function automatic int slot_back(int p, int back);
    return (p % SAMPLE_DEPTH + SAMPLE_DEPTH - back) % SAMPLE_DEPTH;
  endfunction

  // advances one plug's state by one request and returns its result
  function automatic settle_result_t settle_sample(logic [PLUG_NUM_W-1:0] plug,
                                                   logic [CURRENT_W-1:0] cur);
    settle_result_t       res;
    int                   k, dec, nxt, smp, sum, mean, dev, cnt, lim, pen, slot;
    logic [CURRENT_W-1:0] s1, s2, s3;
    logic                 falling;
    res     = '0;
    falling = 1'b0;
    if (plug == 0 || plug > NUM_PLUGS) return res;
    k = plug - 1;

    if (call_cnt[k] < regs.act_gate) call_cnt[k]++;
    dec = (regs.decimation == 0) ? 1 : int'(regs.decimation);
    nxt = int'(phase_cnt[k]) + 1;
    // a phase left over from a larger decimation wraps here as well
    phase_cnt[k] = (nxt >= dec) ? '0 : DEC_W'(nxt);
    if (call_cnt[k] < regs.act_gate || phase_cnt[k] != 0) return res;

    if (overfilled[k]) begin
      s1 = ring[k][slot_back(wr_ptr[k], 2)];
      s2 = ring[k][slot_back(wr_ptr[k], 4)];
      s3 = ring[k][slot_back(wr_ptr[k], 6)];
      falling = (cur < s1) && (s1 < s2) && (s2 < s3);
    end
    if (falling) falling_hits++;
    lim = falling ? int'(regs.fall_limit) : int'(regs.rise_limit);
    pen = falling ? int'(regs.fall_penalty) : int'(regs.rise_penalty);

    sum = 0;
    for (int i = 0; i < SAMPLE_DEPTH - 1; i++) sum += int'(ring[k][i]);
    mean = sum / (SAMPLE_DEPTH - 1);
    smp  = int'(cur);
    dev  = (smp > mean) ? smp - mean : mean - smp;

    cnt = int'(settle_cnt[k]);
    if (dev > int'(regs.fluct_limit)) begin
      cnt = (cnt > pen) ? cnt - pen : 0;
    end else begin
      cnt = (cnt + 1 >= lim) ? lim : cnt + 1;
    end
    settle_cnt[k] = LIMIT_W'(cnt);

    if (overfilled[k]) begin
      slot          = wr_ptr[k] % SAMPLE_DEPTH;
      ring[k][slot] = cur;
      wr_ptr[k]     = (slot + 1) % SAMPLE_DEPTH;
    end else if (wr_ptr[k] >= SAMPLE_DEPTH) begin
      // first write past a full ring goes back to slot 0
      ring[k][0]    = cur;
      wr_ptr[k]     = 1;
      overfilled[k] = 1'b1;
    end else begin
      ring[k][wr_ptr[k]] = cur;
      wr_ptr[k]++;
    end

    if (int'(settle_cnt[k]) == lim) begin
      res.settled        = 1'b1;
      res.stable_current = CURRENT_W'(mean);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    settle_result_t due;
    if (!rst_n) begin
      regs.fluct_limit  = RST_FLUCT_LIMIT;
      regs.fall_limit   = RST_FALL_LIMIT;
      regs.rise_limit   = RST_RISE_LIMIT;
      regs.fall_penalty = RST_FALL_PEN;
      regs.rise_penalty = RST_RISE_PEN;
      regs.decimation   = RST_DECIMATION;
      regs.act_gate     = RST_ACT_GATE;
      for (int k = 0; k < NUM_PLUGS; k++) begin
        call_cnt[k]   = '0;
        phase_cnt[k]  = '0;
        wr_ptr[k]     = 0;
        overfilled[k] = 1'b0;
        settle_cnt[k] = '0;
        for (int j = 0; j < SAMPLE_DEPTH; j++) ring[k][j] = '0;
      end
      settle_results_due.delete();
      errors       = 0;
      pending      = 0;
      settled_hits = 0;
      falling_hits = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_ADDR_W-1:2])
          REG_FLUCT_LIMIT: regs.fluct_limit  = cfg_pwdata[FLUCT_W-1:0];
          REG_FALL_LIMIT:  regs.fall_limit   = cfg_pwdata[LIMIT_W-1:0];
          REG_RISE_LIMIT:  regs.rise_limit   = cfg_pwdata[LIMIT_W-1:0];
          REG_FALL_PEN:    regs.fall_penalty = cfg_pwdata[LIMIT_W-1:0];
          REG_RISE_PEN:    regs.rise_penalty = cfg_pwdata[LIMIT_W-1:0];
          REG_DECIMATION:  regs.decimation   = cfg_pwdata[DEC_W-1:0];
          REG_ACT_GATE:    regs.act_gate     = cfg_pwdata[GATE_W-1:0];
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        if (settle_results_due.size() == 0) begin
          errors++;
          $display("%0t: result with no request waiting: settled %0b current %0d",
                   $time, out_ch.settled, out_ch.stable_current);
        end else begin
          due = settle_results_due.pop_front();
          if (out_ch.settled !== due.settled) begin
            errors++;
            $display("%0t: settled expected %0b actual %0b",
                     $time, due.settled, out_ch.settled);
          end
          if (out_ch.stable_current !== due.stable_current) begin
            errors++;
            $display("%0t: stable_current expected %0d actual %0d",
                     $time, due.stable_current, out_ch.stable_current);
          end
          if (due.settled) settled_hits++;
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        settle_results_due.push_back(settle_sample(in_ch.plug_number, in_ch.demand_current));
      end
      pending = settle_results_due.size();
    end
  end

endmodule

/* tb/sv/demand_current_settler_core_tb.sv */
// ----------------------------------------------------------------------------
// demand_current_settler_core_tb
// Drives current samples for all plug numbers through a series of register
// settings, with random idle bursts on both channels; the checker beside
// the core predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module demand_current_settler_core_tb;
  import dcs_pkg::*;

  localparam int NUM_PLUGS    = 8;
  localparam int SAMPLE_DEPTH = 16;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 168;
  localparam int IDLE_GUARD   = 2;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef enum int {
    WAVE_STEADY,
    WAVE_FALL,
    WAVE_RISE,
    WAVE_NOISE
  } wave_kind_e;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic                  cfg_pready;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;

  int         errors;
  int         pending;
  int         settled_hits;
  int         falling_hits;
  int         sent;
  bit         calm;
  int         level [16];
  wave_kind_e wave  [16];

  dcs_in_if  in_ch ();
  dcs_out_if out_ch ();

  demand_current_settler_core #(
    .NUM_PLUGS    (NUM_PLUGS),
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  demand_current_settler_checker #(
    .NUM_PLUGS    (NUM_PLUGS),
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_pready   (cfg_pready),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .errors       (errors),
    .pending      (pending),
    .settled_hits (settled_hits),
    .falling_hits (falling_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one request, held until the core takes it; returns at the next falling edge
  task automatic send(input int plug, input int cur);
    in_ch.valid          <= 1'b1;
    in_ch.plug_number    <= PLUG_NUM_W'(plug);
    in_ch.demand_current <= CURRENT_W'(cur);
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  // leaves the bus in its access phase so back-to-back writes need no idle cycle
  task automatic cfg_write(input logic [2:0] idx, input int unsigned val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
  endtask

  task automatic load_settings(input int unsigned fl, input int unsigned fal,
                               input int unsigned ril, input int unsigned fp,
                               input int unsigned rp, input int unsigned dec,
                               input int unsigned gate);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (IDLE_GUARD) @(negedge clk);
    cfg_write(REG_FLUCT_LIMIT, fl);
    cfg_write(REG_FALL_LIMIT, fal);
    cfg_write(REG_RISE_LIMIT, ril);
    cfg_write(REG_FALL_PEN, fp);
    cfg_write(REG_RISE_PEN, rp);
    cfg_write(REG_DECIMATION, dec);
    cfg_write(REG_ACT_GATE, gate);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("demand_current_settler_core_tb: errors");
    $finish;
  end

  initial begin : stimulus
    int          n, roll, smp, plug;
    int unsigned fl, fal, ril, fp, rp, dec, gate;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.plug_number    = '0;
    in_ch.demand_current = '0;
    cfg_psel             = 1'b0;
    cfg_penable          = 1'b0;
    cfg_pwrite           = 1'b0;
    cfg_paddr            = '0;
    cfg_pwdata           = '0;
    calm                 = 1'b0;
    sent                 = 0;
    for (int p = 0; p < 16; p++) begin
      level[p] = $urandom_range(0, 65535);
      wave[p]  = WAVE_STEADY;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: invalid plugs and calls still under the activation gate
    send(0, 'hFFFF);
    send(NUM_PLUGS + 1, 0);
    send(15, 'hFFFF);
    send(1, 0);
    send(NUM_PLUGS, 'hFFFF);

    // zero decimation takes every call, zero limits settle at once
    load_settings(500, 0, 0, 6, 1, 0, 0);
    send(2, 'h1234);
    send(2, 'hFFFF);
    send(2, 0);
    send(3, 'hFFFF);

    // build up a phase, then lower decimation below it
    load_settings(500, 18, 3, 6, 1, 5, 2);
    send(4, 100);
    send(4, 100);
    send(4, 100);
    load_settings(500, 18, 3, 6, 1, 2, 2);
    send(4, 100);
    send(4, 'h8000);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          fl = 65535; fal = 31; ril = 31; fp = 0; rp = 0; dec = 1; gate = 0;
        end
        1: begin
          fl = 0; fal = 1; ril = 1; fp = 31; rp = 31; dec = 1; gate = 5;
        end
        2: begin
          // nothing passes the gate here
          fl  = $urandom_range(0, 65535);
          fal = $urandom_range(0, 31);
          ril = $urandom_range(0, 31);
          fp  = $urandom_range(0, 31);
          rp  = $urandom_range(0, 31);
          dec = 63; gate = 65535;
        end
        3: begin
          fl = 800; fal = 0; ril = 0; fp = 2; rp = 2; dec = 0; gate = 0;
        end
        default: begin
          fl   = $urandom_range(40, 2500);
          fal  = $urandom_range(1, 10);
          ril  = $urandom_range(1, 10);
          fp   = $urandom_range(0, 5);
          rp   = $urandom_range(0, 5);
          dec  = $urandom_range(1, 3);
          gate = $urandom_range(0, 40);
        end
      endcase
      load_settings(fl, fal, ril, fp, rp, dec, gate);
      calm = (ph == RAND_PHASES - 1);
      n    = (ph == 2) ? 40 : PHASE_ITEMS;

      repeat (n) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          plug = 0;
        end else if (roll < 8) begin
          plug = $urandom_range(NUM_PLUGS + 1, 15);
        end else if (roll < 50) begin
          // a few busy plugs fill their rings and see long trends
          plug = $urandom_range(1, 3);
        end else begin
          plug = $urandom_range(1, NUM_PLUGS);
        end

        if ($urandom_range(0, 15) == 0) wave[plug] = wave_kind_e'($urandom_range(0, 3));
        case (wave[plug])
          WAVE_STEADY: smp = level[plug] + int'($urandom_range(0, 60)) - 30;
          WAVE_FALL: begin
            level[plug] -= int'($urandom_range(1, 300));
            if (level[plug] < 300) level[plug] = $urandom_range(20000, 65535);
            smp = level[plug];
          end
          WAVE_RISE: begin
            level[plug] += int'($urandom_range(1, 300));
            if (level[plug] > 65000) level[plug] = $urandom_range(0, 5000);
            smp = level[plug];
          end
          default: smp = $urandom_range(0, 65535);
        endcase
        if (smp < 0) smp = 0;
        else if (smp > 65535) smp = 65535;

        if (!calm && $urandom_range(0, 4) == 0) begin
          in_ch.valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        send(plug, smp);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d requests over %0d register settings", sent, RAND_PHASES + 4);
    $display("%0d settled results, %0d samples on a falling trend", settled_hits, falling_hits);
    if (errors == 0) begin
      $display("demand_current_settler_core_tb: clean");
    end else begin
      $display("demand_current_settler_core_tb: errors");
    end
    $finish;
  end

endmodule
